// ===== sv/fnms_pkg.sv =====
// Shared types, constants and helper functions of the fast NMS IoU suppression block.
package fnms_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned AREA_W  = 2 * COORD_W;
  localparam int unsigned UNI_W   = AREA_W + 3;
  localparam int unsigned PROD_W  = THR_W + UNI_W - 1;

  localparam logic [IDX_W-1:0] CFG_IOU_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_KEPT      = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET = 8'd128;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd300;

  typedef struct packed {
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } pipe_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } seq_state_e;

  // Length of the span from lo to hi, zero when the span is negative.
  function automatic logic [COORD_W-1:0] span_len(input logic signed [COORD_W-1:0] hi,
                                                   input logic signed [COORD_W-1:0] lo);
    logic [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    return d[COORD_W] ? '0 : d[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== sv/fnms_if.sv =====
// Handshake interfaces for box requests, results and configuration writes.
interface fnms_box_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          left;
  logic signed [15:0]          top;
  logic signed [15:0]          right;
  logic signed [15:0]          bottom;
  logic                        last_box;
  modport source (output valid, left, top, right, bottom, last_box, input ready);
  modport sink (input valid, left, top, right, bottom, last_box, output ready);
endinterface

interface fnms_res_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [9:0]  box_position;
  logic [9:0]  kept_slot;
  logic [10:0] kept_count;
  logic        overflow;
  modport source (output valid, keep, box_position, kept_slot, kept_count, overflow,
                  input ready);
  modport sink (input valid, keep, box_position, kept_slot, kept_count, overflow,
                output ready);
endinterface

interface fnms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== sv/fnms_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module fnms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/fnms_iou_pipe.sv =====
// Five-stage IoU test of the current box against one stored box per cycle.
module fnms_iou_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         issue_i,
  input  fnms_pkg::box_t               entry_i,
  input  fnms_pkg::box_t               box_i,
  input  logic [fnms_pkg::AREA_W-1:0]  area_i,
  input  logic [fnms_pkg::THR_W-1:0]   thr_i,
  output fnms_pkg::pipe_stat_t         stat_o
);
  import fnms_pkg::*;

  logic                       v0_q, va_q, vb_q, vc_q, vd_q;
  logic [COORD_W-1:0]         w_q, h_q, ew_q, eh_q;
  logic [AREA_W-1:0]          inter_q, earea_q, inter_c_q;
  logic signed [UNI_W-1:0]    uni_q;
  logic [PROD_W-1:0]          prod_q;
  logic [AREA_W+7:0]          lhs_q;
  logic                       pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      v0_q <= issue_i;
      va_q <= v0_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= span_len(smin(box_i.right, entry_i.right), smax(box_i.left, entry_i.left));
    h_q       <= span_len(smin(box_i.bottom, entry_i.bottom), smax(box_i.top, entry_i.top));
    ew_q      <= span_len(entry_i.right, entry_i.left);
    eh_q      <= span_len(entry_i.bottom, entry_i.top);
    inter_q   <= w_q * h_q;
    earea_q   <= ew_q * eh_q;
    uni_q     <= UNI_W'(area_i) + UNI_W'(earea_q) - UNI_W'(inter_q);
    inter_c_q <= inter_q;
    pos_q     <= (uni_q > 0);
    prod_q    <= thr_i * uni_q[UNI_W-2:0];
    lhs_q     <= {inter_c_q, 8'd0};
  end

  assign stat_o.busy = v0_q | va_q | vb_q | vc_q | vd_q;
  assign stat_o.hit  = vd_q & pos_q & (PROD_W'(lhs_q) >= prod_q);

endmodule

// ===== sv/fast_nms_iou_suppress.sv =====
// Top level of the fast NMS IoU suppression block: sequencer, counters and box table.
//
//   channel   direction  carries
//   box_i     in         left, top, right, bottom, last_box
//   res_o     out        keep, box_position, kept_slot, kept_count, overflow
//   cfg_i     in         index, wdata (0: iou_threshold, 1: max_kept)
//
// A request is handled as: area, one table read a cycle into the IoU pipeline (none for an
// empty table), pipeline drain and result write; an overflowing request goes straight to
// its result. box_i is ready again in the cycle after the result is written. Reset clears
// the counters, state and result valid and loads the configuration defaults; the table needs
// no clearing. A new request is taken while a result still waits on res_o; the sequencer
// stalls before writing a second result.
module fast_nms_iou_suppress #(
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fnms_box_if.sink   box_i,
  fnms_res_if.source res_o,
  fnms_cfg_if.sink   cfg_i
);
  import fnms_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  seq_state_e         state_q, state_d;
  box_t               box_q, entry;
  logic               last_q;
  logic [AREA_W-1:0]  area_q;
  logic [CW-1:0]      rd_idx_q, stored_q;
  logic [CAP_W-1:0]   kept_q, maxk_q;
  logic [THR_W-1:0]   thr_q;
  logic               supp_q;
  logic               rd_en, wr_en, finish, ovf, keep;
  pipe_stat_t         stat;

  logic               ovalid_q, okeep_q, oovf_q;
  logic [POS_W-1:0]   opos_q, oslot_q;
  logic [CAP_W-1:0]   ocnt_q;

  assign ovf  = (stored_q == CW'(MAX_BOXES));
  assign keep = !ovf && !supp_q && (kept_q < maxk_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (box_i.valid) state_d = ovf ? ST_DONE : ST_AREA;
      ST_AREA:  state_d = (stored_q == '0) ? ST_DRAIN : ST_SCAN;
      ST_SCAN:  if (rd_idx_q == CW'(stored_q - CW'(1))) state_d = ST_DRAIN;
      ST_DRAIN: if (!stat.busy) state_d = ST_DONE;
      ST_DONE:  if (!ovalid_q || res_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    box_i.ready = (state_q == ST_IDLE);
    rd_en       = (state_q == ST_SCAN);
    finish      = (state_q == ST_DONE) && (!ovalid_q || res_o.ready);
    wr_en       = finish && !ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stored_q <= '0;
      kept_q   <= '0;
      rd_idx_q <= '0;
      supp_q   <= 1'b0;
      thr_q    <= THR_RESET;
      maxk_q   <= CAP_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.index == CFG_IOU_THRESHOLD) thr_q <= cfg_i.wdata[THR_W-1:0];
      if (cfg_i.valid && cfg_i.index == CFG_MAX_KEPT) maxk_q <= cfg_i.wdata;
      if (state_q == ST_AREA) begin
        rd_idx_q <= '0;
        supp_q   <= 1'b0;
      end else begin
        if (rd_en) rd_idx_q <= rd_idx_q + CW'(1);
        if (stat.hit) supp_q <= 1'b1;
      end
      if (finish) begin
        ovalid_q <= 1'b1;
        if (last_q) begin
          stored_q <= '0;
          kept_q   <= '0;
        end else begin
          if (!ovf) stored_q <= stored_q + CW'(1);
          if (keep) kept_q <= kept_q + CAP_W'(1);
        end
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_i.valid && box_i.ready) begin
      box_q  <= '{bottom: box_i.bottom, right: box_i.right, top: box_i.top, left: box_i.left};
      last_q <= box_i.last_box;
    end
    if (state_q == ST_AREA) area_q <= span_len(box_q.right, box_q.left) *
                                      span_len(box_q.bottom, box_q.top);
    if (finish) begin
      okeep_q <= keep;
      oovf_q  <= ovf;
      opos_q  <= ovf ? '0 : POS_W'(stored_q);
      oslot_q <= keep ? POS_W'(kept_q) : '0;
      ocnt_q  <= keep ? kept_q + CAP_W'(1) : kept_q;
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign res_o.valid        = ovalid_q;
  assign res_o.keep         = okeep_q;
  assign res_o.box_position = opos_q;
  assign res_o.kept_slot    = oslot_q;
  assign res_o.kept_count   = ocnt_q;
  assign res_o.overflow     = oovf_q;

  fnms_ram #(
    .WIDTH($bits(box_t)),
    .DEPTH(MAX_BOXES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(stored_q[AW-1:0]),
    .wdata_i(box_q),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(entry)
  );

  fnms_iou_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(rd_en),
    .entry_i(entry),
    .box_i  (box_q),
    .area_i (area_q),
    .thr_i  (thr_q),
    .stat_o (stat)
  );

  a_rd_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> rd_idx_q < stored_q)
    else $error("table read beyond stored entries");

  a_wr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> stored_q < CW'(MAX_BOXES))
    else $error("table write while full");

  a_kept_le_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(kept_q) <= stored_q)
    else $error("kept count exceeds stored count");

  a_no_hit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !stat.busy)
    else $error("IoU pipeline busy outside scan");

  a_ovf_not_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.overflow) |-> !res_o.keep)
    else $error("overflowing box reported as kept");

endmodule

// ===== bench/fnms_checker.sv =====
// Checker that watches the box, result and configuration channels, predicts results and compares them.
module fnms_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  fnms_box_if        box_i,
  fnms_res_if        res_o,
  fnms_cfg_if        cfg_i,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output int         kept_seen,
  output int         overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import fnms_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic        keep;
    logic [9:0]  box_position;
    logic [9:0]  kept_slot;
    logic [10:0] kept_count;
    logic        overflow;
  } verdict_t;

  box_t       boxes[DEPTH];
  int         stored_n;
  int         kept_n;
  logic [7:0] thr;
  logic [10:0] cap;
  verdict_t   verdict_q[$];

  assign pending = verdict_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    fail_count++;
  endtask

  function automatic longint box_area(input box_t bx);
    longint w, h;
    w = longint'(bx.right) - longint'(bx.left);
    h = longint'(bx.bottom) - longint'(bx.top);
    return (w < 0 || h < 0) ? 0 : w * h;
  endfunction

  function automatic verdict_t judge_box(input box_t bx, input logic last);
    verdict_t v;
    longint area, w, h, inter, uni;
    logic hit;
    v = '0;
    hit = 1'b0;
    if (stored_n >= DEPTH) begin
      v.overflow = 1'b1;
    end else begin
      area = box_area(bx);
      for (int i = 0; i < stored_n && !hit; i++) begin
        w = longint'(bx.right < boxes[i].right ? bx.right : boxes[i].right)
            - longint'(bx.left > boxes[i].left ? bx.left : boxes[i].left);
        h = longint'(bx.bottom < boxes[i].bottom ? bx.bottom : boxes[i].bottom)
            - longint'(bx.top > boxes[i].top ? bx.top : boxes[i].top);
        inter = (w < 0 || h < 0) ? 0 : w * h;
        uni = area + box_area(boxes[i]) - inter;
        if (uni > 0 && inter * 256 >= longint'(thr) * uni) hit = 1'b1;
      end
      v.box_position = stored_n[9:0];
      boxes[stored_n] = bx;
      stored_n++;
      if (!hit && kept_n < int'(cap)) begin
        v.keep = 1'b1;
        v.kept_slot = kept_n[9:0];
        kept_n++;
      end
    end
    v.kept_count = kept_n[10:0];
    if (last) begin
      stored_n = 0;
      kept_n = 0;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got, want;
    box_t bx;
    if (!rst_ni) begin
      stored_n = 0;
      kept_n = 0;
      thr = THR_RESET;
      cap = CAP_RESET;
      verdict_q.delete();
      fail_count = 0;
      results_seen = 0;
      kept_seen = 0;
      overflow_seen = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_IOU_THRESHOLD) thr = cfg_i.wdata[7:0];
        else if (cfg_i.index == CFG_MAX_KEPT) cap = cfg_i.wdata;
      end
      if (res_o.valid && res_o.ready) begin
        got = {res_o.keep, res_o.box_position, res_o.kept_slot, res_o.kept_count,
               res_o.overflow};
        results_seen++;
        kept_seen += got.keep;
        overflow_seen += got.overflow;
        if (verdict_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = verdict_q.pop_front();
          if (got.keep != want.keep) report("keep", got.keep, want.keep);
          if (got.box_position != want.box_position)
            report("box_position", got.box_position, want.box_position);
          if (got.kept_slot != want.kept_slot)
            report("kept_slot", got.kept_slot, want.kept_slot);
          if (got.kept_count != want.kept_count)
            report("kept_count", got.kept_count, want.kept_count);
          if (got.overflow != want.overflow)
            report("overflow", got.overflow, want.overflow);
        end
      end
      if (box_i.valid && box_i.ready) begin
        bx.left = box_i.left;
        bx.top = box_i.top;
        bx.right = box_i.right;
        bx.bottom = box_i.bottom;
        verdict_q.push_back(judge_box(bx, box_i.last_box));
      end
    end
  end
endmodule

// ===== bench/fast_nms_iou_suppress_tb.sv =====
// Testbench top: clock, reset, box and configuration stimulus, and the final verdict.
module fast_nms_iou_suppress_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fnms_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, results_seen, kept_seen, overflow_seen;
  int   boxes_sent = 0;

  fnms_box_if box_if();
  fnms_res_if res_if();
  fnms_cfg_if cfg_if();

  fast_nms_iou_suppress uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .box_i(box_if), .res_o(res_if), .cfg_i(cfg_if)
  );

  fnms_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .box_i(box_if), .res_o(res_if), .cfg_i(cfg_if),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .kept_seen(kept_seen), .overflow_seen(overflow_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    box_if.valid = 1'b0;
    box_if.left = '0;
    box_if.top = '0;
    box_if.right = '0;
    box_if.bottom = '0;
    box_if.last_box = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_IOU_THRESHOLD;
    cfg_if.wdata = '0;
  end

  // The receiver stalls for a random number of cycles before each result.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_box(input logic signed [15:0] l, input logic signed [15:0] t,
                          input logic signed [15:0] r, input logic signed [15:0] b,
                          input logic last, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      box_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    box_if.valid <= 1'b1;
    box_if.left <= l;
    box_if.top <= t;
    box_if.right <= r;
    box_if.bottom <= b;
    box_if.last_box <= last;
    do @(posedge clk_i); while (!box_if.ready);
    boxes_sent++;
  endtask

  task automatic drain_results;
    box_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1040) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // A random box near a centre, so that overlaps are common.
  task automatic send_near(input int cx, input int cy, input logic last, input bit burst);
    int l, t;
    l = cx + $signed($urandom_range(0, 64)) - 32;
    t = cy + $signed($urandom_range(0, 64)) - 32;
    send_box(16'(l), 16'(t), 16'(l + $urandom_range(0, 120)),
             16'(t + $urandom_range(0, 120)), last, burst);
  endtask

  task automatic send_random_set(input int n);
    int cx, cy;
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    cx = $urandom_range(0, 2000) - 1000;
    cy = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 i == n - 1, burst);
      else
        send_near(cx, cy, i == n - 1, burst);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0, 1'b0);
    send_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0, 1'b0);
    send_box(16'sd50, 16'sd0, 16'sd150, 16'sd100, 1'b0, 1'b0);
    send_box(16'sd10, 16'sd10, 16'sd5, 16'sd50, 1'b0, 1'b0);
    send_box(16'sd10, 16'sd10, 16'sd10, 16'sd10, 1'b0, 1'b0);
    send_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 1'b0);
    send_box(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0, 1'b0);
    send_box(-16'sd32768, 16'sd0, -16'sd32767, 16'sd1, 1'b1, 1'b0);

    write_reg(CFG_IOU_THRESHOLD, 11'd0);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0, 1'b0);
    send_box(16'sd9, 16'sd9, 16'sd20, 16'sd20, 1'b0, 1'b0);
    send_box(16'sd100, 16'sd100, 16'sd200, 16'sd200, 1'b0, 1'b0);
    send_box(16'sd5, 16'sd5, 16'sd1, 16'sd1, 1'b1, 1'b0);
    write_reg(CFG_IOU_THRESHOLD, 11'd255);
    write_reg(CFG_MAX_KEPT, 11'd0);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0, 1'b0);
    send_box(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b1, 1'b0);
    write_reg(CFG_MAX_KEPT, 11'd2);
    for (int i = 0; i < 4; i++)
      send_box(16'(i * 100), 16'sd0, 16'(i * 100 + 50), 16'sd50, i == 3, 1'b0);
    write_reg(2'd3, 11'h7FF);
    write_reg(2'd2, 11'h155);

    for (int s = 0; s < 60; s++) begin
      if (s % 10 == 0) begin
        write_reg(CFG_IOU_THRESHOLD, 11'($urandom_range(1, 255)));
        write_reg(CFG_MAX_KEPT, (s == 20) ? 11'd1024 : (s == 30) ? 11'd1
                                 : 11'($urandom_range(1, 12)));
      end
      if (s == 25) drain_results();
      send_random_set($urandom_range(1, 16));
    end

    // One long set of boxes that do not overlap, sent back to back.
    write_reg(CFG_MAX_KEPT, 11'd1024);
    write_reg(CFG_IOU_THRESHOLD, 11'd255);
    for (int i = 0; i < 48; i++)
      send_box(16'(i * 4), 16'sd0, 16'(i * 4 + 3), 16'sd3, i == 47, 1'b1);
    send_box(16'sd0, 16'sd0, 16'sd3, 16'sd3, 1'b1, 1'b0);

    drain_results();
    $display("Sent %0d boxes; %0d results checked, %0d kept, %0d overflowed.",
             boxes_sent, results_seen, kept_seen, overflow_seen);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
